// ===== rtl/x86alu_pkg.sv =====
`default_nettype none
package x86alu_pkg;

    localparam logic [3:0] OP_ADC  = 4'd0;
    localparam logic [3:0] OP_SBB  = 4'd1;
    localparam logic [3:0] OP_AND  = 4'd2;
    localparam logic [3:0] OP_OR   = 4'd3;
    localparam logic [3:0] OP_XOR  = 4'd4;
    localparam logic [3:0] OP_CMP  = 4'd5;
    localparam logic [3:0] OP_TEST = 4'd6;
    localparam logic [3:0] OP_INC  = 4'd7;
    localparam logic [3:0] OP_DEC  = 4'd8;
    localparam logic [3:0] OP_MUL  = 4'd9;
    localparam logic [3:0] OP_IMUL = 4'd10;
    localparam logic [3:0] OP_DIV  = 4'd11;
    localparam logic [3:0] OP_IDIV = 4'd12;
    localparam logic [3:0] OP_SHL  = 4'd13;
    localparam logic [3:0] OP_SHR  = 4'd14;
    localparam logic [3:0] OP_SAR  = 4'd15;

    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_WORD  = 2'd1;
    localparam logic [1:0] SZ_DWORD = 2'd2;

    localparam int F_CF = 0;
    localparam int F_PF = 1;
    localparam int F_AF = 2;
    localparam int F_ZF = 3;
    localparam int F_SF = 4;
    localparam int F_OF = 5;

    // Number of quotient-bit stages in the divider.
    localparam int DIV_STAGES = 32;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  size;
        logic [5:0]  fin;
        logic [5:0]  flags;
        logic        derr;
        logic [63:0] work;
        logic [31:0] dvs;
        logic        nq;
        logic        nn;
    } t_item;

    function automatic logic [31:0] wmask(input logic [1:0] size);
        unique case (size)
            SZ_BYTE: wmask = 32'h0000_00FF;
            SZ_WORD: wmask = 32'h0000_FFFF;
            default: wmask = 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic msb(input logic [31:0] x, input logic [1:0] size);
        unique case (size)
            SZ_BYTE: msb = x[7];
            SZ_WORD: msb = x[15];
            default: msb = x[31];
        endcase
    endfunction

    function automatic logic [31:0] sx(input logic [31:0] x, input logic [1:0] size);
        unique case (size)
            SZ_BYTE: sx = {{24{x[7]}}, x[7:0]};
            SZ_WORD: sx = {{16{x[15]}}, x[15:0]};
            default: sx = x;
        endcase
    endfunction

    // ZF, SF and PF of a result already masked to the operand width.
    function automatic logic [5:0] szp(input logic [31:0] res, input logic [1:0] size);
        logic [5:0] f;
        f = '0;
        f[F_ZF] = (res == 32'd0);
        f[F_SF] = msb(res, size);
        f[F_PF] = ~(^res[7:0]);
        szp = f;
    endfunction

    function automatic logic is_div(input logic [3:0] op);
        is_div = (op == OP_DIV) || (op == OP_IDIV);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/x86alu_front.sv =====
`default_nettype none
module x86alu_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire          [3:0]  i_op,
    input  wire          [1:0]  i_size,
    input  wire          [63:0] i_dst,
    input  wire          [31:0] i_src,
    input  wire                 i_carry_in,
    input  wire          [7:0]  i_count,
    input  wire          [5:0]  i_flags_in,
    output logic                o_valid,
    output x86alu_pkg::t_item   o_item
);

    logic               r_valid;
    x86alu_pkg::t_item  r_item;
    x86alu_pkg::t_item  n_item;

    logic [31:0] m, a, b, res, sv, d, ud;
    logic [32:0] sum, dif, inc, dec, ma, mb;
    logic [65:0] prod;
    logic [63:0] wide, n, un;
    logic [4:0]  cnt, cm1;
    logic [5:0]  f;
    logic        cf, nn, nd;

    always_comb begin
        m    = x86alu_pkg::wmask(i_size);
        a    = i_dst[31:0] & m;
        b    = i_src & m;
        cnt  = i_count[4:0];
        cm1  = cnt - 5'd1;
        sum  = {1'b0, a} + {1'b0, b} + {32'd0, i_carry_in};
        dif  = {1'b0, a} - {1'b0, b} - {32'd0, i_carry_in};
        inc  = {1'b0, a} + 33'd1;
        dec  = {1'b0, a} - 33'd1;
        sv   = x86alu_pkg::sx(a, i_size);
        ma   = (i_op == x86alu_pkg::OP_IMUL) ? {sv[31], sv} : {1'b0, a};
        d    = x86alu_pkg::sx(b, i_size);
        mb   = (i_op == x86alu_pkg::OP_IMUL) ? {d[31], d} : {1'b0, b};
        prod = 66'($signed(ma) * $signed(mb));
        wide = {32'd0, a} << cnt;
        res  = '0;
        f    = i_flags_in;
        cf   = 1'b0;
        nn   = 1'b0;
        nd   = 1'b0;
        n    = '0;
        un   = '0;
        ud   = '0;

        n_item       = '0;
        n_item.op    = i_op;
        n_item.size  = i_size;
        n_item.fin   = i_flags_in;

        unique case (i_op)
            x86alu_pkg::OP_ADC: begin
                res = sum[31:0] & m;
                f = x86alu_pkg::szp(res, i_size);
                unique case (i_size)
                    x86alu_pkg::SZ_BYTE: f[x86alu_pkg::F_CF] = sum[8];
                    x86alu_pkg::SZ_WORD: f[x86alu_pkg::F_CF] = sum[16];
                    default:             f[x86alu_pkg::F_CF] = sum[32];
                endcase
                f[x86alu_pkg::F_OF] = x86alu_pkg::msb(~(a ^ b) & (a ^ res), i_size);
                f[x86alu_pkg::F_AF] = a[4] ^ b[4] ^ res[4];
            end
            x86alu_pkg::OP_SBB, x86alu_pkg::OP_CMP: begin
                if (i_op == x86alu_pkg::OP_CMP) begin
                    dif = {1'b0, a} - {1'b0, b};
                end
                res = dif[31:0] & m;
                f = x86alu_pkg::szp(res, i_size);
                f[x86alu_pkg::F_CF] = dif[32];
                f[x86alu_pkg::F_OF] = x86alu_pkg::msb((a ^ b) & (a ^ res), i_size);
                f[x86alu_pkg::F_AF] = a[4] ^ b[4] ^ res[4];
                if (i_op == x86alu_pkg::OP_CMP) begin
                    res = a;
                end
            end
            x86alu_pkg::OP_AND, x86alu_pkg::OP_TEST: begin
                res = a & b;
                f = x86alu_pkg::szp(res, i_size);
                f[x86alu_pkg::F_AF] = i_flags_in[x86alu_pkg::F_AF];
                if (i_op == x86alu_pkg::OP_TEST) begin
                    res = a;
                end
            end
            x86alu_pkg::OP_OR, x86alu_pkg::OP_XOR: begin
                res = (i_op == x86alu_pkg::OP_OR) ? (a | b) : (a ^ b);
                f = x86alu_pkg::szp(res, i_size);
                f[x86alu_pkg::F_AF] = i_flags_in[x86alu_pkg::F_AF];
            end
            x86alu_pkg::OP_INC: begin
                res = inc[31:0] & m;
                f = x86alu_pkg::szp(res, i_size);
                f[x86alu_pkg::F_CF] = i_flags_in[x86alu_pkg::F_CF];
                f[x86alu_pkg::F_OF] = x86alu_pkg::msb(~(a ^ 32'd1) & (a ^ res), i_size);
                f[x86alu_pkg::F_AF] = a[4] ^ res[4];
            end
            x86alu_pkg::OP_DEC: begin
                res = dec[31:0] & m;
                f = x86alu_pkg::szp(res, i_size);
                f[x86alu_pkg::F_CF] = i_flags_in[x86alu_pkg::F_CF];
                f[x86alu_pkg::F_OF] = x86alu_pkg::msb((a ^ 32'd1) & (a ^ res), i_size);
                f[x86alu_pkg::F_AF] = a[4] ^ res[4];
            end
            x86alu_pkg::OP_MUL, x86alu_pkg::OP_IMUL: begin
                f = i_flags_in;
            end
            x86alu_pkg::OP_DIV, x86alu_pkg::OP_IDIV: begin
                if (i_op == x86alu_pkg::OP_IDIV) begin
                    unique case (i_size)
                        x86alu_pkg::SZ_BYTE: n = {{48{i_dst[15]}}, i_dst[15:0]};
                        x86alu_pkg::SZ_WORD: n = {{32{i_dst[31]}}, i_dst[31:0]};
                        default:             n = i_dst;
                    endcase
                    nn = n[63];
                    nd = d[31];
                    un = nn ? (64'd0 - n) : n;
                    ud = nd ? (32'd0 - d) : d;
                end else begin
                    unique case (i_size)
                        x86alu_pkg::SZ_BYTE: un = {48'd0, i_dst[15:0]};
                        x86alu_pkg::SZ_WORD: un = {32'd0, i_dst[31:0]};
                        default:             un = i_dst;
                    endcase
                    ud = b;
                end
            end
            default: begin
                // shl, shr, sar
                if (cnt != 5'd0) begin
                    f = i_flags_in & 6'b100100;
                    if (i_op == x86alu_pkg::OP_SHL) begin
                        res = wide[31:0] & m;
                        unique case (i_size)
                            x86alu_pkg::SZ_BYTE: cf = wide[8];
                            x86alu_pkg::SZ_WORD: cf = wide[16];
                            default:             cf = wide[32];
                        endcase
                        if (cnt == 5'd1) begin
                            f[x86alu_pkg::F_OF] = x86alu_pkg::msb(res, i_size) ^ cf;
                        end
                    end else if (i_op == x86alu_pkg::OP_SHR) begin
                        res = a >> cnt;
                        cf  = a[cm1];
                        if (cnt == 5'd1) begin
                            f[x86alu_pkg::F_OF] = x86alu_pkg::msb(a, i_size);
                        end
                    end else begin
                        res = 32'($signed(sv) >>> cnt) & m;
                        cf  = sv[cm1];
                        if (cnt == 5'd1) begin
                            f[x86alu_pkg::F_OF] = 1'b0;
                        end
                    end
                    f = f | x86alu_pkg::szp(res, i_size);
                    f[x86alu_pkg::F_CF] = cf;
                end else begin
                    res = a;
                end
            end
        endcase

        n_item.flags = f;
        n_item.nq    = nn ^ nd;
        n_item.nn    = nn;
        n_item.dvs   = ud;
        if (x86alu_pkg::is_div(i_op)) begin
            n_item.work = un;
            n_item.derr = (ud == 32'd0) || (un[63:32] >= ud);
        end else if (i_op == x86alu_pkg::OP_MUL || i_op == x86alu_pkg::OP_IMUL) begin
            n_item.work = prod[63:0];
        end else begin
            n_item.work = {32'd0, res};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// ===== rtl/x86alu_div_step.sv =====
`default_nettype none
module x86alu_div_step (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire x86alu_pkg::t_item  i_item,
    output logic                    o_valid,
    output x86alu_pkg::t_item       o_item
);

    logic               r_valid;
    x86alu_pkg::t_item  r_item;
    x86alu_pkg::t_item  n_item;
    logic [32:0]        t;
    logic [33:0]        dif;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        n_item = i_item;
        t      = {i_item.work[63:32], i_item.work[31]};
        dif    = {1'b0, t} - {2'b00, i_item.dvs};
        if (x86alu_pkg::is_div(i_item.op) && !i_item.derr) begin
            if (!dif[33]) begin
                n_item.work = {dif[31:0], i_item.work[30:0], 1'b1};
            end else begin
                n_item.work = {t[31:0], i_item.work[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// ===== rtl/x86alu_back.sv =====
`default_nettype none
module x86alu_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire x86alu_pkg::t_item  i_item,
    output logic                    o_valid,
    output logic             [63:0] o_result,
    output logic             [5:0]  o_flags_out,
    output logic                    o_divide_error
);

    logic        r_valid;
    logic [63:0] r_result, n_result;
    logic [5:0]  r_flags, n_flags;
    logic        r_derr, n_derr;

    logic [31:0] q, r, m, lim, qs, rs;
    logic [63:0] p;
    logic        ov;

    always_comb begin
        p    = i_item.work;
        q    = i_item.work[31:0];
        r    = i_item.work[63:32];
        m    = x86alu_pkg::wmask(i_item.size);
        lim  = 32'd1 << (x86alu_pkg::msb(32'h0000_0080, i_item.size) ? 5'd7 :
               x86alu_pkg::msb(32'h0000_8000, i_item.size) ? 5'd15 : 5'd31);
        qs   = i_item.nq ? (32'd0 - q) : q;
        rs   = i_item.nn ? (32'd0 - r) : r;
        ov   = 1'b0;
        n_result = i_item.work;
        n_flags  = i_item.flags;
        n_derr   = i_item.derr;

        unique case (i_item.op)
            x86alu_pkg::OP_MUL: begin
                unique case (i_item.size)
                    x86alu_pkg::SZ_BYTE: ov = (p[15:8] != 8'd0);
                    x86alu_pkg::SZ_WORD: ov = (p[31:16] != 16'd0);
                    default:             ov = (p[63:32] != 32'd0);
                endcase
                n_flags[x86alu_pkg::F_CF] = ov;
                n_flags[x86alu_pkg::F_OF] = ov;
            end
            x86alu_pkg::OP_IMUL: begin
                unique case (i_item.size)
                    x86alu_pkg::SZ_BYTE: begin
                        ov = !((&p[63:7]) || (~|p[63:7]));
                        n_result = {48'd0, p[15:0]};
                    end
                    x86alu_pkg::SZ_WORD: begin
                        ov = !((&p[63:15]) || (~|p[63:15]));
                        n_result = {32'd0, p[31:0]};
                    end
                    default: ov = !((&p[63:31]) || (~|p[63:31]));
                endcase
                n_flags[x86alu_pkg::F_CF] = ov;
                n_flags[x86alu_pkg::F_OF] = ov;
            end
            x86alu_pkg::OP_DIV, x86alu_pkg::OP_IDIV: begin
                n_flags = i_item.fin;
                if (i_item.op == x86alu_pkg::OP_DIV) begin
                    ov = ((q & ~m) != 32'd0);
                    qs = q;
                    rs = r;
                end else begin
                    ov = i_item.nq ? (q > lim) : (q > lim - 32'd1);
                end
                n_derr = i_item.derr || ov;
                unique case (i_item.size)
                    x86alu_pkg::SZ_BYTE: n_result = {48'd0, rs[7:0], qs[7:0]};
                    x86alu_pkg::SZ_WORD: n_result = {32'd0, rs[15:0], qs[15:0]};
                    default:             n_result = {rs, qs};
                endcase
                if (n_derr) begin
                    n_result = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
            r_flags  <= n_flags;
            r_derr   <= n_derr;
        end
    end

    assign o_valid        = r_valid;
    assign o_result       = r_result;
    assign o_flags_out    = r_flags;
    assign o_divide_error = r_derr;

endmodule
`default_nettype wire

// ===== rtl/x86_integer_alu_flags.sv =====
`default_nettype none
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_op i_size i_dst i_src i_carry_in i_count i_flags_in
// output    out        o_valid / i_stall  o_result o_flags_out o_divide_error
//
// One transfer in per cycle, one result out per cycle, in order, while the output is not stalled.
// Every op passes through the same stages: front stage, 32 divider stages, back stage.
// The 32 one-bit restoring divide steps set the depth; other ops ride along.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only.
// A stalled output holds the whole pipe; o_stall rises only then.
module x86_integer_alu_flags (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [3:0]  i_op,
    input  wire  [1:0]  i_size,
    input  wire  [63:0] i_dst,
    input  wire  [31:0] i_src,
    input  wire         i_carry_in,
    input  wire  [7:0]  i_count,
    input  wire  [5:0]  i_flags_in,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [63:0] o_result,
    output logic [5:0]  o_flags_out,
    output logic        o_divide_error
);

    logic                en;
    logic                v   [x86alu_pkg::DIV_STAGES+1];
    x86alu_pkg::t_item   itm [x86alu_pkg::DIV_STAGES+1];

    // Advance everything unless a finished result is waiting to be taken.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    x86alu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_op       (i_op),
        .i_size     (i_size),
        .i_dst      (i_dst),
        .i_src      (i_src),
        .i_carry_in (i_carry_in),
        .i_count    (i_count),
        .i_flags_in (i_flags_in),
        .o_valid    (v[0]),
        .o_item     (itm[0])
    );

    // Divider: one quotient bit per stage, MSB first.
    for (genvar g = 0; g < x86alu_pkg::DIV_STAGES; g++) begin : g_div
        x86alu_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_item  (itm[g]),
            .o_valid (v[g+1]),
            .o_item  (itm[g+1])
        );
    end

    // Finish multiplies and divides, then hold the result for transfer.
    x86alu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (v[x86alu_pkg::DIV_STAGES]),
        .i_item         (itm[x86alu_pkg::DIV_STAGES]),
        .o_valid        (o_valid),
        .o_result       (o_result),
        .o_flags_out    (o_flags_out),
        .o_divide_error (o_divide_error)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import x86alu_pkg::*;

    // Pipeline depth from the block header: front stage, 32 divide stages, back stage.
    localparam int PIPE_DEPTH = 34;

    // Unused size encoding; the block treats it as doubleword.
    localparam logic [1:0] SZ_ODD = 2'd3;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  size;
        logic [63:0] dst;
        logic [31:0] src;
        logic        cin;
        logic [7:0]  count;
        logic [5:0]  fin;
    } t_alu_req;

    typedef struct packed {
        logic [63:0] result;
        logic [5:0]  flags;
        logic        derr;
    } t_alu_rsp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_op;
    logic [1:0]  i_size;
    logic [63:0] i_dst;
    logic [31:0] i_src;
    logic        i_carry_in;
    logic [7:0]  i_count;
    logic [5:0]  i_flags_in;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result;
    logic [5:0]  o_flags_out;
    logic        o_divide_error;

    x86_integer_alu_flags i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_size        (i_size),
        .i_dst         (i_dst),
        .i_src         (i_src),
        .i_carry_in    (i_carry_in),
        .i_count       (i_count),
        .i_flags_in    (i_flags_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result      (o_result),
        .o_flags_out   (o_flags_out),
        .o_divide_error(o_divide_error)
    );

    t_alu_rsp pending_rsp[$];
    int       n_errors;
    bit       quiet_mode;   // no idling on either side in the closing part
    bit       hold_on;      // long receiver hold-off in progress
    event     hold_start;
    int       stall_left;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    // ---------------- flag predictor ----------------
    function automatic logic [5:0] zsp_flags(input logic [63:0] r, input int w);
        logic [5:0]  f;
        logic [63:0] m;
        m = (64'd1 << w) - 64'd1;
        f = '0;
        f[F_ZF] = ((r & m) == 64'd0);
        f[F_SF] = r[w-1];
        f[F_PF] = ~(^r[7:0]);
        return f;
    endfunction

    function automatic logic [63:0] sign_ext(input logic [63:0] x, input int w);
        logic [63:0] m;
        if (w >= 64) return x;
        m = (64'd1 << w) - 64'd1;
        x = x & m;
        if (x[w-1]) x = x | ~m;
        return x;
    endfunction

    // Add or subtract with carry; returns the masked result and sets flags.
    function automatic logic [63:0] add_sub(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] c, input bit sub,
                                            input int w, output logic [5:0] f);
        logic [63:0] m, full, r, ov;
        m = (64'd1 << w) - 64'd1;
        full = sub ? (a - b - c) : (a + b + c);
        r = full & m;
        f = zsp_flags(r, w);
        f[F_CF] = sub ? (a < b + c) : full[w];
        ov = sub ? ((a ^ b) & (a ^ r)) : (~(a ^ b) & (a ^ r));
        f[F_OF] = ov[w-1];
        f[F_AF] = a[4] ^ b[4] ^ r[4];
        return r;
    endfunction

    function automatic t_alu_rsp alu_predict(input t_alu_req q);
        t_alu_rsp    y;
        int          w, cnt;
        logic [63:0] m, m2, a, b, r, n, d, un, ud, qt, rm, lim, prod, sv;
        logic [5:0]  f, nf;
        bit          derr, nn, nd, nq, cf;
        w = (q.size == SZ_BYTE) ? 8 : (q.size == SZ_WORD) ? 16 : 32;
        m = (64'd1 << w) - 64'd1;
        m2 = (w == 32) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << (2 * w)) - 64'd1);
        a = q.dst & m;
        b = {32'd0, q.src} & m;
        cnt = int'(q.count[4:0]);
        f = q.fin;
        r = '0;
        derr = 0;
        case (q.op)
            OP_ADC: r = add_sub(a, b, {63'd0, q.cin}, 1'b0, w, f);
            OP_SBB: r = add_sub(a, b, {63'd0, q.cin}, 1'b1, w, f);
            OP_AND, OP_OR, OP_XOR, OP_TEST: begin
                r = (q.op == OP_OR) ? (a | b) : (q.op == OP_XOR) ? (a ^ b) : (a & b);
                f = zsp_flags(r, w);
                f[F_AF] = q.fin[F_AF];
                if (q.op == OP_TEST) r = a;
            end
            OP_CMP: begin
                void'(add_sub(a, b, 64'd0, 1'b1, w, f));
                r = a;
            end
            OP_INC, OP_DEC: begin
                r = add_sub(a, 64'd1, 64'd0, q.op == OP_DEC, w, nf);
                f = nf;
                f[F_CF] = q.fin[F_CF];
            end
            OP_MUL: begin
                r = a * b;
                f[F_CF] = ((r >> w) != 64'd0);
                f[F_OF] = f[F_CF];
            end
            OP_IMUL: begin
                prod = sign_ext(a, w) * sign_ext(b, w);
                r = prod & m2;
                f[F_CF] = (sign_ext(prod, w) != prod);
                f[F_OF] = f[F_CF];
            end
            OP_DIV: begin
                n = q.dst & m2;
                if (b == 64'd0 || n / b > m) derr = 1;
                else r = ((n % b) << w) | (n / b);
            end
            OP_IDIV: begin
                n = sign_ext(q.dst, 2 * w);
                d = sign_ext(b, w);
                nn = n[63];
                nd = d[63];
                nq = nn != nd;
                un = nn ? -n : n;
                ud = nd ? -d : d;
                if (ud == 64'd0) derr = 1;
                else begin
                    qt = un / ud;
                    rm = un % ud;
                    lim = 64'd1 << (w - 1);
                    if (nq ? (qt > lim) : (qt > lim - 64'd1)) derr = 1;
                    else begin
                        if (nq) qt = -qt;
                        if (nn) rm = -rm;
                        r = ((rm & m) << w) | (qt & m);
                    end
                end
            end
            default: begin
                if (cnt == 0) r = a;
                else begin
                    f = q.fin & 6'b100100;  // keep AF and OF
                    if (q.op == OP_SHL) begin
                        prod = a << cnt;
                        r = prod & m;
                        cf = prod[w];
                        if (cnt == 1) f[F_OF] = r[w-1] ^ cf;
                    end else if (q.op == OP_SHR) begin
                        r = a >> cnt;
                        cf = a[cnt-1];
                        if (cnt == 1) f[F_OF] = a[w-1];
                    end else begin
                        sv = sign_ext(a, w);
                        r = (sv[63] ? ~((~sv) >> cnt) : (sv >> cnt)) & m;
                        cf = sv[cnt-1];
                        if (cnt == 1) f[F_OF] = 1'b0;
                    end
                    f = f | zsp_flags(r, w);
                    f[F_CF] = cf;
                end
            end
        endcase
        if (derr) begin
            r = '0;
            f = q.fin;
        end
        y.result = r;
        y.flags = f;
        y.derr = derr;
        return y;
    endfunction

    // ---------------- sender ----------------
    task automatic send_op(input t_alu_req q);
        int gap;
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= q.op;
        i_size     <= q.size;
        i_dst      <= q.dst;
        i_src      <= q.src;
        i_carry_in <= q.cin;
        i_count    <= q.count;
        i_flags_in <= q.fin;
        pending_rsp.push_back(alu_predict(q));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic t_alu_req rand_req(input logic [3:0] op);
        t_alu_req q;
        q.op = op;
        q.size = 2'($urandom_range(0, 3));
        q.dst = {$urandom, $urandom};
        q.src = $urandom;
        case ($urandom_range(0, 5))
            0: q.src = '0;
            1: q.src = '1;
            2: q.src = $urandom_range(0, 3);
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: q.dst = '0;
            1: q.dst = '1;
            2: q.dst = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom};
            default: ;
        endcase
        // Keep a good share of divides in range so the quotient path is reached.
        if ((op == OP_DIV || op == OP_IDIV) && $urandom_range(0, 1)) begin
            q.dst = {32'd0, $urandom} >> $urandom_range(0, 31);
            if (q.src == 32'd0) q.src = $urandom_range(1, 255);
            if (op == OP_IDIV && $urandom_range(0, 1)) q.dst = -q.dst;
        end
        q.cin = 1'($urandom_range(0, 1));
        q.count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2))
                                              : 8'($urandom_range(0, 255));
        q.fin = 6'($urandom_range(0, 63));
        return q;
    endfunction

    function automatic t_alu_req mk(input logic [3:0] op, input logic [1:0] size,
                                    input logic [63:0] dst, input logic [31:0] src,
                                    input logic cin, input logic [7:0] count,
                                    input logic [5:0] fin);
        t_alu_req q;
        q.op = op; q.size = size; q.dst = dst; q.src = src;
        q.cin = cin; q.count = count; q.fin = fin;
        return q;
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        send_op(mk(OP_ADC, SZ_BYTE, 64'h7F, 32'h1, 1'b1, 8'h0, 6'h00));
        send_op(mk(OP_ADC, SZ_DWORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF,
                   6'h3F));
        send_op(mk(OP_SBB, SZ_WORD, 64'h0, 32'h1, 1'b1, 8'h0, 6'h00));
        send_op(mk(OP_AND, SZ_ODD, 64'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b0, 8'h0, 6'h3F));
        send_op(mk(OP_OR,  SZ_BYTE, 64'h80, 32'h01, 1'b0, 8'h0, 6'h04));
        send_op(mk(OP_XOR, SZ_WORD, 64'hFFFF, 32'hFFFF, 1'b0, 8'h0, 6'h00));
        send_op(mk(OP_CMP, SZ_BYTE, 64'h1234_5680, 32'h01, 1'b1, 8'h0, 6'h00));
        send_op(mk(OP_TEST, SZ_DWORD, 64'hDEAD_BEEF_8000_0000, 32'h8000_0000, 1'b0, 8'h0,
                   6'h3B));
        send_op(mk(OP_INC, SZ_BYTE, 64'h7F, 32'h0, 1'b0, 8'h0, 6'h01));
        send_op(mk(OP_DEC, SZ_WORD, 64'h0, 32'h0, 1'b0, 8'h0, 6'h00));
        send_op(mk(OP_MUL, SZ_DWORD, 64'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h0, 6'h1E));
        send_op(mk(OP_IMUL, SZ_BYTE, 64'h80, 32'h80, 1'b0, 8'h0, 6'h00));
        send_op(mk(OP_IMUL, SZ_WORD, 64'h2, 32'hFFFF, 1'b0, 8'h0, 6'h3F));
        send_op(mk(OP_DIV, SZ_BYTE, 64'h1234, 32'h0, 1'b0, 8'h0, 6'h15));
        send_op(mk(OP_DIV, SZ_BYTE, 64'h1234, 32'h10, 1'b0, 8'h0, 6'h2A));
        send_op(mk(OP_DIV, SZ_DWORD, 64'hFFFF_FFFE_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h0,
                   6'h00));
        send_op(mk(OP_IDIV, SZ_WORD, 64'hFFFF_8000, 32'hFFFF, 1'b0, 8'h0, 6'h00));
        send_op(mk(OP_IDIV, SZ_BYTE, 64'hFF80, 32'h01, 1'b0, 8'h0, 6'h00));
        send_op(mk(OP_IDIV, SZ_DWORD, 64'hFFFF_FFFF_FFFF_FFF9, 32'h2, 1'b0, 8'h0, 6'h00));
        send_op(mk(OP_SHL, SZ_DWORD, 64'hC000_0001, 32'h0, 1'b0, 8'h01, 6'h00));
        send_op(mk(OP_SHL, SZ_BYTE, 64'hFF, 32'h0, 1'b0, 8'h29, 6'h24));
        send_op(mk(OP_SHR, SZ_WORD, 64'h8001, 32'h0, 1'b0, 8'h01, 6'h00));
        send_op(mk(OP_SHR, SZ_BYTE, 64'hAB, 32'h0, 1'b0, 8'hE0, 6'h3F));
        send_op(mk(OP_SAR, SZ_BYTE, 64'h81, 32'h0, 1'b0, 8'h1F, 6'h20));
        send_op(mk(OP_SAR, SZ_DWORD, 64'h8000_0000, 32'h0, 1'b0, 8'h01, 6'h20));
    endtask

    task automatic test_random(input int n_items);
        repeat (n_items) send_op(rand_req(4'($urandom_range(0, 15))));
    endtask

    // Receiver holds off while the sender keeps offering, so the pipe fills.
    task automatic test_backpressure();
        -> hold_start;
        repeat (80) send_op(rand_req(4'($urandom_range(0, 15))));
    endtask

    task automatic test_full_rate();
        quiet_mode = 1'b1;
        repeat (200) send_op(rand_req(4'($urandom_range(0, 15))));
    endtask

    // ---------------- receiver hold-off ----------------
    always begin
        @(hold_start);
        hold_on <= 1'b1;
        repeat (120) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // ---------------- receiver stall ----------------
    // Random stall bursts of random length, or the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (hold_on) begin
            i_stall <= 1'b1;
        end else if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ---------------- checker ----------------
    always @(posedge i_clk) begin
        t_alu_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected transfer, result %h flags %h derr %b", $time,
                         o_result, o_flags_out, o_divide_error);
                n_errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_result !== want.result) begin
                    $display("%0t: result expected %h actual %h", $time, want.result,
                             o_result);
                    n_errors++;
                end
                if (o_flags_out !== want.flags) begin
                    $display("%0t: flags expected %h actual %h", $time, want.flags,
                             o_flags_out);
                    n_errors++;
                end
                if (o_divide_error !== want.derr) begin
                    $display("%0t: divide_error expected %b actual %b", $time, want.derr,
                             o_divide_error);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        n_errors = 0;
        quiet_mode = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = '0; i_size = '0; i_dst = '0; i_src = '0;
        i_carry_in = 1'b0; i_count = '0; i_flags_in = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(700);
        test_backpressure();
        test_random(650);
        test_full_rate();
        i_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        if (n_errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
